// ----- src/co2fd_pkg.sv -----
`timescale 1ns / 1ps

package co2fd_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // last byte of a response, counted from zero
    localparam logic [3:0] LAST_POS = 4'd8;

    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_CRC
    } phase_t;

    // one complete response as handed from front to back
    typedef struct packed {
        logic        status;
        logic [1:0]  bad_word;
        logic [15:0] co2_word;
        logic [15:0] temp_word;
        logic [15:0] hum_word;
    } frame_rec_t;

    // crc-8, msb first, one byte folded in
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^31
    function automatic logic [15:0] div_65535(input logic [30:0] x);
        logic [31:0] sum;
        sum = {1'b0, x} + {16'b0, 1'b0, x[30:16]} + 32'd1;
        return sum[31:16];
    endfunction

endpackage

// ----- src/co2fd_front.sv -----
`timescale 1ns / 1ps

module co2fd_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_byte,
    input  logic                   in_start,
    output logic                   push,
    output co2fd_pkg::frame_rec_t  push_rec,
    input  logic                   queue_full
);

    logic [3:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg;
    logic [7:0]  hold_reg;
    logic [15:0] co2_reg, temp_reg, hum_reg;
    logic [1:0]  bad_reg, bad_next;

    logic [3:0]        pos_eff;
    co2fd_pkg::phase_t phase;
    logic [1:0]        word_idx;
    logic [1:0]        bad_base;
    logic [7:0]        crc_calc;
    logic              accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        pos_eff = (in_start || pos_reg > co2fd_pkg::LAST_POS) ? 4'd0 : pos_reg;
        unique case (pos_eff)
            4'd0, 4'd3, 4'd6: phase = co2fd_pkg::PH_HIGH;
            4'd1, 4'd4, 4'd7: phase = co2fd_pkg::PH_LOW;
            4'd2, 4'd5, 4'd8: phase = co2fd_pkg::PH_CRC;
            default:          phase = co2fd_pkg::PH_HIGH;
        endcase
        unique case (pos_eff)
            4'd3, 4'd4, 4'd5: word_idx = 2'd1;
            4'd6, 4'd7, 4'd8: word_idx = 2'd2;
            default:          word_idx = 2'd0;
        endcase
    end

    always_comb begin
        bad_base = (pos_eff == 4'd0) ? 2'd0 : bad_reg;
        crc_calc = co2fd_pkg::crc8_feed(
            (phase == co2fd_pkg::PH_HIGH) ? co2fd_pkg::CRC_INIT : crc_reg, in_byte);
        bad_next = bad_base;
        if (phase == co2fd_pkg::PH_CRC && crc_reg != in_byte && bad_base == 2'd0) begin
            bad_next = word_idx + 2'd1;
        end
        push     = accept && (pos_eff == co2fd_pkg::LAST_POS);
        pos_next = push ? 4'd0 : pos_eff + 4'd1;
    end

    always_comb begin
        push_rec.status    = (bad_next != 2'd0);
        push_rec.bad_word  = bad_next;
        push_rec.co2_word  = co2_reg;
        push_rec.temp_word = temp_reg;
        push_rec.hum_word  = hum_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 4'd0;
            bad_reg <= 2'd0;
        end else if (accept) begin
            pos_reg <= pos_next;
            bad_reg <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (phase != co2fd_pkg::PH_CRC) begin
                crc_reg <= crc_calc;
            end
            if (phase == co2fd_pkg::PH_HIGH) begin
                hold_reg <= in_byte;
            end
            if (phase == co2fd_pkg::PH_LOW) begin
                unique case (word_idx)
                    2'd0:    co2_reg  <= {hold_reg, in_byte};
                    2'd1:    temp_reg <= {hold_reg, in_byte};
                    default: hum_reg  <= {hold_reg, in_byte};
                endcase
            end
        end
    end

endmodule

// ----- src/co2fd_queue.sv -----
`timescale 1ns / 1ps

module co2fd_queue #(
    parameter int unsigned DEPTH = co2fd_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  co2fd_pkg::frame_rec_t push_rec,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output co2fd_pkg::frame_rec_t head_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

    co2fd_pkg::frame_rec_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_rec   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ----- src/co2fd_back.sv -----
`timescale 1ns / 1ps

module co2fd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  co2fd_pkg::frame_rec_t head_rec,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [47:0]           out_data
);

    logic              advance;
    logic              s1_valid_reg;
    logic              s1_status_reg;
    logic [1:0]        s1_bad_reg;
    logic [15:0]       s1_co2_reg;
    logic [30:0]       s1_tprod_reg;
    logic [29:0]       s1_hprod_reg;

    logic              out_valid_reg;
    logic [47:0]       out_data_reg;

    logic [15:0]        t_quot;
    logic [15:0]        h_quot;
    logic signed [14:0] temp_centi;

    // whole pipe moves together when the output register can take a request
    assign advance   = !out_valid_reg || out_ready;
    assign pop       = head_valid && advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        t_quot     = co2fd_pkg::div_65535(s1_tprod_reg);
        h_quot     = co2fd_pkg::div_65535({1'b0, s1_hprod_reg});
        temp_centi = signed'(t_quot[14:0] - co2fd_pkg::TEMP_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= head_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_status_reg <= head_rec.status;
            s1_bad_reg    <= head_rec.bad_word;
            s1_co2_reg    <= head_rec.co2_word;
            s1_tprod_reg  <= 31'(head_rec.temp_word) * 31'(co2fd_pkg::TEMP_SPAN);
            s1_hprod_reg  <= 30'(head_rec.hum_word) * 30'(co2fd_pkg::HUM_SPAN);
            out_data_reg  <= {h_quot[13:0], temp_centi, s1_co2_reg, s1_bad_reg,
                              s1_status_reg};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[0] == (out_data_reg[2:1] != 2'd0)))
        else $error("status disagrees with bad word index");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_data_reg[47:34] <= co2fd_pkg::HUM_SPAN))
        else $error("humidity beyond full scale");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ($signed(out_data_reg[33:19]) >= -15'sd4500
                           && $signed(out_data_reg[33:19]) <= 15'sd13000))
        else $error("temperature out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(s1_valid_reg)))
        else $error("pipe moved while output stalled");

endmodule

// ----- src/co2_sensor_frame_decoder_core.sv -----
`timescale 1ns / 1ps

// channel   direction  tdata fields (lsb up)                          tuser
// s_        in         data_byte[7:0]                                 frame_start
// m_        out        status, bad_word[2:1], co2_ppm[18:3],          -
//                      temperature_centi[33:19], humidity_centi[47:34]
//
// takes one byte request per cycle while s_tready is high; m_tvalid rises once the
// frame of the ninth accepted byte has passed queue write, multiply stage, scale stage
// the 16x15 multiply and the divide-by-65535 add each own one register stage
// reset clears byte position, bad word index, queue count and pipe valids
// output stall holds the back pipe; the queue absorbs it and s_tready drops
// only when the queue is full
module co2_sensor_frame_decoder_core #(
    parameter int unsigned QUEUE_DEPTH = co2fd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic [0:0]  s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status, bad_word, co2_ppm, temperature_centi,
                                   // humidity_centi
);

    // finished frames travel front -> queue -> back
    logic                  push;
    co2fd_pkg::frame_rec_t push_rec;
    logic                  queue_full;
    logic                  pop;
    logic                  head_valid;
    co2fd_pkg::frame_rec_t head_rec;

    // front: byte position, per-word crc check, word capture
    co2fd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_start   (s_tuser[0]),
        .push       (push),
        .push_rec   (push_rec),
        .queue_full (queue_full)
    );

    // short queue decoupling byte intake from result delivery
    co2fd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_rec   (push_rec),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // back: fixed-point scaling of temperature and humidity, output register
    co2fd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule

// ----- dv/co2_sensor_frame_decoder_core_tb.sv -----
`timescale 1ns / 1ps

// one decoded response as it leaves on m_tdata, lowest field in bit 0
typedef struct packed {
    logic [13:0] humidity_centi;
    logic [14:0] temperature_centi;
    logic [15:0] co2_ppm;
    logic [1:0]  bad_word;
    logic        status;
} meas_result_t;

// tracks the byte stream and predicts the decoded measurement of each response
class frame_scoreboard;
    logic [3:0]     byte_pos;
    logic [7:0]     crc_acc;
    logic [7:0]     high_hold;
    logic [15:0]    co2_w;
    logic [15:0]    temp_w;
    logic [15:0]    hum_w;
    logic [1:0]     first_bad;
    meas_result_t   pending_meas_q[$];
    int unsigned    failures;

    function new();
        byte_pos  = '0;
        crc_acc   = 8'hFF;
        high_hold = '0;
        co2_w     = '0;
        temp_w    = '0;
        hum_w     = '0;
        first_bad = '0;
        failures  = 0;
    endfunction

    // crc-8, poly 0x31, msb first
    static function logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // one accepted byte request
    function void note_byte(input logic [7:0] b, input logic frame_mark);
        logic [3:0]   pos;
        int unsigned  widx;
        int unsigned  ph;
        int           t;
        meas_result_t r;
        pos = frame_mark ? 4'd0 : byte_pos;
        if (pos > 4'd8) begin
            pos = 4'd0;
        end
        if (pos == 4'd0) begin
            first_bad = '0;
        end
        widx = pos / 3;
        ph   = pos % 3;
        if (ph == 0) begin
            high_hold = b;
            crc_acc   = crc_byte(8'hFF, b);
        end else if (ph == 1) begin
            crc_acc = crc_byte(crc_acc, b);
            case (widx)
                0:       co2_w  = {high_hold, b};
                1:       temp_w = {high_hold, b};
                default: hum_w  = {high_hold, b};
            endcase
        end else if (crc_acc != b && first_bad == 2'd0) begin
            first_bad = 2'(widx + 1);
        end
        if (pos == 4'd8) begin
            t = -4500 + int'((32'd17500 * 32'(temp_w)) / 32'd65535);
            r.status            = (first_bad != 2'd0);
            r.bad_word          = first_bad;
            r.co2_ppm           = co2_w;
            r.temperature_centi = t[14:0];
            r.humidity_centi    = 14'((32'd10000 * 32'(hum_w)) / 32'd65535);
            pending_meas_q.push_back(r);
            byte_pos = 4'd0;
        end else begin
            byte_pos = pos + 4'd1;
        end
    endfunction

    // one accepted result, compared with the oldest prediction
    function void check_result(input logic [47:0] raw);
        meas_result_t got;
        meas_result_t exp_r;
        got = raw;
        if (pending_meas_q.size() == 0) begin
            if (failures < 10) begin
                $display("unexpected result %h with nothing pending", raw);
            end
            failures++;
            return;
        end
        exp_r = pending_meas_q.pop_front();
        if (got.status !== exp_r.status || got.bad_word !== exp_r.bad_word ||
            got.co2_ppm !== exp_r.co2_ppm ||
            got.temperature_centi !== exp_r.temperature_centi ||
            got.humidity_centi !== exp_r.humidity_centi) begin
            if (failures < 10) begin
                $display("mismatch: status %0d/%0d bad_word %0d/%0d co2 %0d/%0d",
                         exp_r.status, got.status, exp_r.bad_word, got.bad_word,
                         exp_r.co2_ppm, got.co2_ppm);
                $display("          temp %0d/%0d humidity %0d/%0d (expected/actual)",
                         $signed(exp_r.temperature_centi), $signed(got.temperature_centi),
                         exp_r.humidity_centi, got.humidity_centi);
            end
            failures++;
        end
    endfunction
endclass

module co2_sensor_frame_decoder_core_tb;

    localparam int unsigned IDLE_LIMIT   = 3000;   // cycles with no handshake on either side
    localparam int unsigned LONG_HOLD    = 300;    // receiver hold-off that fills the block
    localparam int unsigned RANDOM_BYTES = 930;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // data_byte
    logic [0:0]  s_tuser  = '0;    // frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // status, bad_word, co2_ppm, temperature_centi,
                                   // humidity_centi

    frame_scoreboard meas_sb = new();

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_epoch  = 0;  // bumped by the stimulus to ask for a long hold-off
    int unsigned hold_seen   = 0;
    int unsigned hold_left   = 0;
    int unsigned sent_bytes  = 0;

    co2_sensor_frame_decoder_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver: random back-pressure, or a long hold-off when asked for
    always @(posedge aclk) begin
        if (hold_epoch != hold_seen) begin
            hold_seen <= hold_epoch;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // every accepted result goes straight to the checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            meas_sb.check_result(m_tdata);
        end
    end

    // watchdog: ends the run if neither side moves for too long
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("co2_sensor_frame_decoder_core verification failed");
        $finish;
    end

    // one byte request, with random sender gaps ahead of it
    task automatic send_byte(input logic [7:0] b, input logic frame_mark);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= frame_mark;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        meas_sb.note_byte(b, frame_mark);
        sent_bytes++;
    endtask

    // a full response; bad_crc picks the words whose crc byte gets flipped
    task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
                              input logic [15:0] w2, input logic [2:0] bad_crc,
                              input logic frame_mark);
        logic [15:0] words [3];
        logic [7:0]  crc;
        words[0] = w0;
        words[1] = w1;
        words[2] = w2;
        for (int w = 0; w < 3; w++) begin
            crc = meas_sb.crc_byte(meas_sb.crc_byte(8'hFF, words[w][15:8]),
                                   words[w][7:0]);
            if (bad_crc[w]) begin
                crc ^= 8'($urandom_range(255, 1));
            end
            send_byte(words[w][15:8], (w == 0) && frame_mark);
            send_byte(words[w][7:0], 1'b0);
            send_byte(crc, 1'b0);
        end
    endtask

    // sender stops until every predicted result has arrived
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (meas_sb.pending_meas_q.size() != 0);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly clean or lightly corrupted responses, some cut short, some noise
    task automatic random_chunk();
        int unsigned kind;
        int unsigned cut_len;
        logic [2:0]  bad_crc;
        kind = $urandom_range(99);
        if (kind < 80) begin
            for (int w = 0; w < 3; w++) begin
                bad_crc[w] = ($urandom_range(5) == 0);
            end
            send_frame(pick_word(), pick_word(), pick_word(), bad_crc,
                       $urandom_range(3) != 0);
        end else if (kind < 92) begin
            // response dropped partway after opening with the mark; the next one may lack it
            cut_len = $urandom_range(8, 1);
            for (int i = 0; i < cut_len; i++) begin
                send_byte(8'($urandom), i == 0);
            end
        end else begin
            send_byte(8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial begin : stimulus
        int unsigned phase_end;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, wrap without a mark, restart mid-frame, crc failures
        send_frame(16'h0000, 16'hFFFF, 16'hFFFF, 3'b000, 1'b1);
        send_frame(16'hFFFF, 16'h0000, 16'h0000, 3'b101, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h55, 1'b0);
        send_frame(16'h1234, 16'h8000, 16'h0001, 3'b110, 1'b1);
        wait_drain();

        // three load phases: slow receiver, slow sender, then full rate
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 74 : 0;
            rx_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 34 : 0;
            if (ph == 2) begin
                // receiver holds off while the sender keeps pushing requests
                hold_epoch <= hold_epoch + 1;
            end
            phase_end = sent_bytes + RANDOM_BYTES / 3;
            while (sent_bytes < phase_end) begin
                random_chunk();
            end
            wait_drain();
        end

        // let any stray result show up before the verdict
        repeat (20) @(posedge aclk);
        if (meas_sb.failures == 0 && meas_sb.pending_meas_q.size() == 0) begin
            $display("co2_sensor_frame_decoder_core verification clean");
        end else begin
            $display("co2_sensor_frame_decoder_core verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/co2fd_pkg.sv
src/co2fd_front.sv
src/co2fd_queue.sv
src/co2fd_back.sv
src/co2_sensor_frame_decoder_core.sv
dv/co2_sensor_frame_decoder_core_tb.sv
